@@ hw/rtl/alc_pkg.sv @@
// Package: sizes, widths and state encoding for the agglomerative linkage clustering unit.
package alc_pkg;

  localparam int MAX_POINTS = 32;
  localparam int DIST_BITS  = 16;

  localparam int IDX_W  = $clog2(MAX_POINTS);
  localparam int PT_W   = IDX_W + 1;
  localparam int ADDR_W = 2 * IDX_W;
  localparam int SUM_W  = DIST_BITS + 2 * IDX_W;
  localparam int MRG_W  = DIST_BITS + 8;
  localparam int NUM_W  = SUM_W + 8;
  localparam int DEN_W  = 2 * PT_W;
  localparam int DCNT_W = $clog2(NUM_W);
  localparam int CFG_W  = 6;

  typedef enum logic [1:0] {
    LINK_SINGLE   = 2'd0,
    LINK_COMPLETE = 2'd1,
    LINK_AVERAGE  = 2'd2,
    LINK_NONE     = 2'd3
  } link_e;

  typedef enum logic {
    REG_LINKAGE_MODE = 1'b0,
    REG_NUM_POINTS   = 1'b1
  } reg_idx_e;

  typedef enum logic [9:0] {
    ST_IDLE     = 10'b00_0000_0001,
    ST_COPY     = 10'b00_0000_0010,
    ST_SCAN_A   = 10'b00_0000_0100,
    ST_SCAN_B   = 10'b00_0000_1000,
    ST_EVAL     = 10'b00_0001_0000,
    ST_DIV      = 10'b00_0010_0000,
    ST_CMP      = 10'b00_0100_0000,
    ST_MRG_INIT = 10'b00_1000_0000,
    ST_MRG_C    = 10'b01_0000_0000,
    ST_MRG_P    = 10'b10_0000_0000
  } state_e;

endpackage

@@ hw/rtl/agglomerative_linkage_clustering_unit.sv @@
// Agglomerative linkage clustering: distance matrix store, linkage matrix and merge sequencer.
// Load: one matrix element per cycle while busy is low; the receiver cannot stall results.
// After the last element (mode not none, n >= 2): a copy of all distance memory to the linkage
// memory, then per round one pass over active pairs (serial divide per pair in average mode) and
// a merge update of each other active cluster; one result strobe per merge, busy drops after the
// last. Reset: mode single, 32 points, all clusters active; the distance memory is not reset.
module agglomerative_linkage_clustering_unit
  import alc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [IDX_W-1:0]     row_index_i,
  input  logic [IDX_W-1:0]     col_index_i,
  input  logic [DIST_BITS-1:0] distance_i,
  input  logic                 last_element_i,
  input  logic                 cfg_we_i,
  input  logic                 cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  output logic                 out_valid_o,
  output logic [IDX_W-1:0]     left_point_o,
  output logic [IDX_W-1:0]     right_point_o,
  output logic [MRG_W-1:0]     merge_distance_o,
  output logic                 last_merge_o
);

  state_e state_q, state_d;

  logic [1:0]      mode_q;
  logic [CFG_W-1:0] npts_q;

  logic [DIST_BITS-1:0] dmem [2**ADDR_W];
  logic [SUM_W-1:0]     wmem [2**ADDR_W];
  logic [DIST_BITS-1:0] drd_q;
  logic [SUM_W-1:0]     wrd_q;

  logic [MAX_POINTS-1:0] active_q;
  logic [PT_W-1:0]       size_q [MAX_POINTS];

  logic [PT_W-1:0]   n_q, a_q, b_q, c_q, act_cnt_q, size_a_q;
  logic [ADDR_W-1:0] cp_q, cp_wa_q;
  logic              cp_wv_q;
  logic [2:0]        ph_q;
  logic [SUM_W-1:0]  tmp_q;
  logic [DEN_W-1:0]  den_q;
  logic [DEN_W:0]    rem_q;
  logic [NUM_W-1:0]  quo_q;
  logic [DCNT_W-1:0] dcnt_q;
  logic [MRG_W-1:0]  cand_q, best_q;
  logic              found_q;
  logic [IDX_W-1:0]  ba_q, bb_q;

  logic              accept, run;
  logic [PT_W-1:0]   n_new;
  logic [IDX_W-1:0]  size_sel;
  logic [PT_W-1:0]   size_rd;
  logic [ADDR_W-1:0] waddr_rd, waddr_wr;
  logic              wwe;
  logic [SUM_W-1:0]  wdata, comb;
  logic [DEN_W:0]    rem_sh, rem_nx;
  logic              ge;
  logic [NUM_W-1:0]  quo_nx;

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;
  assign n_new  = (PT_W'(npts_q) > PT_W'(MAX_POINTS)) ? PT_W'(MAX_POINTS) : PT_W'(npts_q);
  assign run    = accept && last_element_i && (mode_q != LINK_NONE) && (n_new >= PT_W'(2));

  always_comb begin
    size_sel = b_q[IDX_W-1:0];
    if (state_q == ST_SCAN_A) size_sel = a_q[IDX_W-1:0];
    else if (state_q == ST_MRG_INIT) size_sel = bb_q;
  end
  assign size_rd = size_q[size_sel];

  always_comb begin
    case (mode_q)
      LINK_SINGLE:   comb = (tmp_q < wrd_q) ? tmp_q : wrd_q;
      LINK_COMPLETE: comb = (tmp_q > wrd_q) ? tmp_q : wrd_q;
      default:       comb = tmp_q + wrd_q;
    endcase
  end

  always_comb begin
    waddr_rd = {a_q[IDX_W-1:0], b_q[IDX_W-1:0]};
    if (state_q == ST_MRG_P) begin
      case (ph_q)
        3'd0:    waddr_rd = {ba_q, c_q[IDX_W-1:0]};
        3'd1:    waddr_rd = {bb_q, c_q[IDX_W-1:0]};
        3'd2:    waddr_rd = {c_q[IDX_W-1:0], ba_q};
        default: waddr_rd = {c_q[IDX_W-1:0], bb_q};
      endcase
    end
  end

  always_comb begin
    wwe      = 1'b0;
    waddr_wr = cp_wa_q;
    wdata    = SUM_W'(drd_q);
    if (cp_wv_q) begin
      wwe = 1'b1;
    end else if (state_q == ST_MRG_P && ph_q == 3'd2) begin
      wwe      = 1'b1;
      waddr_wr = {ba_q, c_q[IDX_W-1:0]};
      wdata    = comb;
    end else if (state_q == ST_MRG_P && ph_q == 3'd4) begin
      wwe      = 1'b1;
      waddr_wr = {c_q[IDX_W-1:0], ba_q};
      wdata    = comb;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) dmem[{row_index_i, col_index_i}] <= distance_i;
    drd_q <= dmem[cp_q];
  end

  always_ff @(posedge clk_i) begin
    if (wwe) wmem[waddr_wr] <= wdata;
    wrd_q <= wmem[waddr_rd];
  end

  assign rem_sh = {rem_q[DEN_W-1:0], quo_q[NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, den_q};
  assign rem_nx = ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
  assign quo_nx = {quo_q[NUM_W-2:0], ge};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:     if (run) state_d = ST_COPY;
      ST_COPY:     if (cp_q == '1) state_d = ST_SCAN_A;
      ST_SCAN_A: begin
        if (a_q >= n_q - PT_W'(1)) state_d = ST_MRG_INIT;
        else if (active_q[a_q[IDX_W-1:0]]) state_d = ST_SCAN_B;
      end
      ST_SCAN_B: begin
        if (b_q >= n_q) state_d = ST_SCAN_A;
        else if (active_q[b_q[IDX_W-1:0]]) state_d = ST_EVAL;
      end
      ST_EVAL:     state_d = (mode_q == LINK_AVERAGE) ? ST_DIV : ST_CMP;
      ST_DIV:      if (dcnt_q == DCNT_W'(NUM_W - 1)) state_d = ST_CMP;
      ST_CMP:      state_d = ST_SCAN_B;
      ST_MRG_INIT: state_d = ST_MRG_C;
      ST_MRG_C: begin
        if (c_q >= n_q) state_d = (act_cnt_q == PT_W'(1)) ? ST_IDLE : ST_SCAN_A;
        else if (active_q[c_q[IDX_W-1:0]] && c_q[IDX_W-1:0] != ba_q) state_d = ST_MRG_P;
      end
      ST_MRG_P:    if (ph_q == 3'd4) state_d = ST_MRG_C;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= LINK_SINGLE;
      npts_q      <= CFG_W'(32);
      active_q    <= '1;
      for (int p = 0; p < MAX_POINTS; p++) size_q[p] <= PT_W'(1);
      cp_q        <= '0;
      cp_wa_q     <= '0;
      cp_wv_q     <= 1'b0;
      found_q     <= 1'b0;
      out_valid_o <= 1'b0;
      act_cnt_q   <= '0;
      n_q         <= '0;
      a_q         <= '0;
      b_q         <= '0;
      c_q         <= '0;
      ph_q        <= '0;
      dcnt_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_o <= 1'b0;
      cp_wv_q     <= (state_q == ST_COPY);
      cp_wa_q     <= cp_q;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_LINKAGE_MODE: mode_q <= cfg_data_i[1:0];
          REG_NUM_POINTS:   npts_q <= cfg_data_i;
          default:          ;
        endcase
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept && last_element_i) begin
            for (int p = 0; p < MAX_POINTS; p++) begin
              active_q[p] <= (PT_W'(p) < n_new);
              size_q[p]   <= PT_W'(1);
            end
          end
          if (run) begin
            n_q       <= n_new;
            act_cnt_q <= n_new;
            cp_q      <= '0;
            a_q       <= '0;
            found_q   <= 1'b0;
          end
        end
        ST_COPY: cp_q <= cp_q + ADDR_W'(1);
        ST_SCAN_A: begin
          if (a_q < n_q - PT_W'(1)) begin
            if (active_q[a_q[IDX_W-1:0]]) begin
              b_q      <= a_q + PT_W'(1);
              size_a_q <= size_rd;
            end else begin
              a_q <= a_q + PT_W'(1);
            end
          end
        end
        ST_SCAN_B: begin
          if (b_q >= n_q) a_q <= a_q + PT_W'(1);
          else if (active_q[b_q[IDX_W-1:0]]) den_q <= DEN_W'(size_a_q) * DEN_W'(size_rd);
          else b_q <= b_q + PT_W'(1);
        end
        ST_EVAL: begin
          cand_q <= {wrd_q[DIST_BITS-1:0], 8'h00};
          rem_q  <= '0;
          quo_q  <= {wrd_q, 8'h00};
          dcnt_q <= '0;
        end
        ST_DIV: begin
          rem_q  <= rem_nx;
          quo_q  <= quo_nx;
          dcnt_q <= dcnt_q + DCNT_W'(1);
          if (dcnt_q == DCNT_W'(NUM_W - 1)) cand_q <= quo_nx[MRG_W-1:0];
        end
        ST_CMP: begin
          if (!found_q || cand_q < best_q) begin
            found_q <= 1'b1;
            best_q  <= cand_q;
            ba_q    <= a_q[IDX_W-1:0];
            bb_q    <= b_q[IDX_W-1:0];
          end
          b_q <= b_q + PT_W'(1);
        end
        ST_MRG_INIT: begin
          out_valid_o      <= 1'b1;
          left_point_o     <= ba_q;
          right_point_o    <= bb_q;
          merge_distance_o <= best_q;
          last_merge_o     <= (act_cnt_q == PT_W'(2));
          size_q[ba_q]     <= size_q[ba_q] + size_rd;
          active_q[bb_q]   <= 1'b0;
          act_cnt_q        <= act_cnt_q - PT_W'(1);
          c_q              <= '0;
        end
        ST_MRG_C: begin
          if (c_q >= n_q) begin
            a_q     <= '0;
            found_q <= 1'b0;
          end else if (active_q[c_q[IDX_W-1:0]] && c_q[IDX_W-1:0] != ba_q) begin
            ph_q <= '0;
          end else begin
            c_q <= c_q + PT_W'(1);
          end
        end
        ST_MRG_P: begin
          ph_q <= ph_q + 3'd1;
          if (ph_q == 3'd1 || ph_q == 3'd3) tmp_q <= wrd_q;
          if (ph_q == 3'd4) c_q <= c_q + PT_W'(1);
        end
        default: ;
      endcase
    end
  end

endmodule

@@ test/tb_top.sv @@
// Testbench for the agglomerative linkage clustering unit: random matrices, predicted merges.
module tb_top
  import alc_pkg::*;
();

  typedef struct packed {
    logic [IDX_W-1:0]     row;
    logic [IDX_W-1:0]     col;
    logic [DIST_BITS-1:0] dval;
    logic                 last;
  } elem_t;

  typedef struct packed {
    logic [IDX_W-1:0] left;
    logic [IDX_W-1:0] right;
    logic [MRG_W-1:0] mdist;
    logic             last;
  } merge_t;

  localparam int WATCHDOG_LIMIT = 400000;
  localparam int SETTLE_CYCLES  = 1100;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [IDX_W-1:0]     row_index_i = '0;
  logic [IDX_W-1:0]     col_index_i = '0;
  logic [DIST_BITS-1:0] distance_i = '0;
  logic                 last_element_i = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic                 cfg_idx_i = 1'b0;
  logic [CFG_W-1:0]     cfg_data_i = '0;
  logic                 out_valid_o;
  logic [IDX_W-1:0]     left_point_o;
  logic [IDX_W-1:0]     right_point_o;
  logic [MRG_W-1:0]     merge_distance_o;
  logic                 last_merge_o;

  elem_t  pending_elems[$];
  merge_t expected_merges[$];
  logic [DIST_BITS-1:0] dist_mem[MAX_POINTS*MAX_POINTS];
  bit   written[MAX_POINTS*MAX_POINTS];
  link_e mdl_mode = LINK_SINGLE;
  int    mdl_points = 32;
  int    send_idle_pct = 31;
  int    errors = 0;
  int    stall_cycles = 0;
  int    pushed = 0;

  agglomerative_linkage_clustering_unit u_top (.*);

  always #5 clk_i = ~clk_i;

  task automatic report_mismatch(input string msg);
    $display("ERROR %s", msg);
    errors++;
  endtask

  function automatic logic [63:0] linkage(input int lbl[MAX_POINTS], input int n,
                                          input int a, input int b);
    logic [63:0] best, sum, cnt, d;
    bit first;
    best = 0; sum = 0; cnt = 0; first = 1;
    for (int p = 0; p < n; p++) begin
      if (lbl[p] != a) continue;
      for (int q = 0; q < n; q++) begin
        if (lbl[q] != b) continue;
        d = dist_mem[p*MAX_POINTS+q];
        if (mdl_mode == LINK_SINGLE) begin
          if (first || d < best) best = d;
        end else if (mdl_mode == LINK_COMPLETE) begin
          if (d > best) best = d;
        end else begin
          sum += d;
          cnt++;
        end
        first = 0;
      end
    end
    if (mdl_mode == LINK_AVERAGE) return cnt != 0 ? (sum << 8) / cnt : 0;
    return best << 8;
  endfunction

  task automatic predict_merges(input elem_t e);
    int lbl[MAX_POINTS];
    bit act[MAX_POINTS];
    int n, remaining, ba, bb;
    logic [63:0] best, d;
    bit found;
    merge_t m;
    dist_mem[e.row*MAX_POINTS+e.col] = e.dval;
    if (!e.last || mdl_mode == LINK_NONE) return;
    n = mdl_points > MAX_POINTS ? MAX_POINTS : mdl_points;
    for (int p = 0; p < MAX_POINTS; p++) begin
      lbl[p] = p;
      act[p] = p < n;
    end
    remaining = n;
    while (remaining > 1) begin
      found = 0; best = 0; ba = 0; bb = 0;
      for (int a = 0; a < n; a++) begin
        if (!act[a]) continue;
        for (int b = a + 1; b < n; b++) begin
          if (!act[b]) continue;
          d = linkage(lbl, n, a, b);
          if (!found || d < best) begin
            found = 1; best = d; ba = a; bb = b;
          end
        end
      end
      for (int p = 0; p < n; p++) if (lbl[p] == bb) lbl[p] = ba;
      act[bb] = 0;
      remaining--;
      m.left = ba[IDX_W-1:0];
      m.right = bb[IDX_W-1:0];
      m.mdist = best[MRG_W-1:0];
      m.last = remaining == 1;
      expected_merges = {expected_merges, m};
    end
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    elem_t e;
    bit take;
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      take = 0;
      if (start && !busy) begin
        predict_merges({row_index_i, col_index_i, distance_i, last_element_i});
        stall_cycles = 0;
      end
      if (!(start && busy)) begin
        if (pending_elems.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          e = pending_elems.pop_front();
          row_index_i <= e.row;
          col_index_i <= e.col;
          distance_i <= e.dval;
          last_element_i <= e.last;
          take = 1;
        end
        start <= take;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    merge_t exp_m;
    if (rst_ni && out_valid_o) begin
      stall_cycles = 0;
      if (expected_merges.size() == 0) begin
        report_mismatch($sformatf("unexpected merge %0d-%0d", left_point_o, right_point_o));
      end else begin
        exp_m = expected_merges.pop_front();
        if (left_point_o !== exp_m.left)
          report_mismatch($sformatf("left_point %0d exp %0d", left_point_o, exp_m.left));
        if (right_point_o !== exp_m.right)
          report_mismatch($sformatf("right_point %0d exp %0d", right_point_o, exp_m.right));
        if (merge_distance_o !== exp_m.mdist)
          report_mismatch($sformatf("merge_distance %0h exp %0h", merge_distance_o,
                                    exp_m.mdist));
        if (last_merge_o !== exp_m.last)
          report_mismatch($sformatf("last_merge %0b exp %0b", last_merge_o, exp_m.last));
      end
    end
  end

  always @(posedge clk_i) begin
    stall_cycles++;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic wait_idle();
    while (pending_elems.size() != 0 || start || expected_merges.size() != 0 || busy)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input int value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value[CFG_W-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_LINKAGE_MODE) mdl_mode = link_e'(value[1:0]);
    else mdl_points = value[CFG_W-1:0];
  endtask

  function automatic logic [DIST_BITS-1:0] rand_dist();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2, 3: return DIST_BITS'($urandom);
      default: return DIST_BITS'($urandom_range(7));
    endcase
  endfunction

  task automatic push_elem(input int r, input int c, input bit last);
    elem_t e;
    e.row = IDX_W'(r); e.col = IDX_W'(c); e.dval = rand_dist(); e.last = last;
    written[r*MAX_POINTS+c] = 1;
    pending_elems = {pending_elems, e};
    pushed++;
  endtask

  // one configuration, then elements covering every entry the run can read not yet written
  task automatic run_set(input link_e mode, input int n);
    int c, lr, lc;
    bit all_set;
    wait_idle();
    write_reg(REG_LINKAGE_MODE, mode);
    write_reg(REG_NUM_POINTS, n);
    c = n > MAX_POINTS ? MAX_POINTS : n;
    all_set = 1;
    for (int i = 0; i < c; i++)
      for (int j = 0; j < c; j++)
        if (i != j && !written[i*MAX_POINTS+j]) all_set = 0;
    if ($urandom_range(3) == 0) push_elem($urandom_range(31), $urandom_range(31), 0);
    if (c < 2 || (all_set && c > 8)) begin
      for (int k = 0; k < 3; k++) push_elem($urandom_range(c > 1 ? c-1 : 31), $urandom_range(31), 0);
    end else begin
      for (int i = 0; i < c; i++)
        for (int j = 0; j < c; j++)
          if (i != j && !(i == c-1 && j == c-2)) push_elem(i, j, 0);
    end
    lr = c >= 2 ? c-1 : $urandom_range(31);
    lc = c >= 2 ? c-2 : $urandom_range(31);
    push_elem(lr, lc, 1);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    run_set(LINK_SINGLE, 2);
    run_set(LINK_COMPLETE, 3);
    run_set(LINK_AVERAGE, 3);
    run_set(LINK_NONE, 3);
    run_set(LINK_SINGLE, 1);
    run_set(LINK_AVERAGE, 0);
    while (pushed < 95) begin
      if (pushed > 50) send_idle_pct = 66;
      run_set(link_e'($urandom_range(9) == 0 ? 3 : $urandom_range(2)),
              $urandom_range(7) == 0 ? $urandom_range(0, 8) : $urandom_range(2, 5));
    end
    send_idle_pct = 0;
    run_set(LINK_AVERAGE, 11);
    run_set(LINK_SINGLE, 11);
    run_set(LINK_COMPLETE, 11);
    run_set(link_e'($urandom_range(2)), $urandom_range(2, 6));
    wait_idle();
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

@@ files.f @@
hw/rtl/alc_pkg.sv
hw/rtl/agglomerative_linkage_clustering_unit.sv
test/tb_top.sv
